### sv/bb3_pkg.sv
// Shared types and constants for the 3x3 box blur.
// Used by the channel interfaces, the column cell, the top level and the checker.
package bb3_pkg;

  localparam int PIX_W      = 8;
  localparam int CSUM_W     = 10;  // three pixels
  localparam int SUM_W      = 12;  // nine pixels
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int FW_BITS    = 11;  // stored bits of frame_width
  localparam int FH_BITS    = 13;  // stored bits of frame_height

  localparam int RESET_WIDTH  = 1024;
  localparam int RESET_HEIGHT = 1;

  // floor(x / 9) == (x * DIV9_MUL) >> DIV9_SHIFT for every x below 2^15
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;
  localparam int PROD_W     = 24;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [CSUM_W-1:0]     csum_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_FRAME_HEIGHT = cfg_idx_t'(1);

  // one window column, row 0 is two lines above the input row
  typedef logic [2:0][PIX_W-1:0] col_t;

  typedef struct packed {
    logic shift;  // take the neighbour's column
    logic clr;    // take zero instead
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0] row_en;
    logic       col_en;
  } sum_en_t;

  typedef struct packed {
    logic [2:0] row_en;
    logic [2:0] col_en;
  } win_mask_t;

endpackage

### sv/bb3_if.sv
// Valid/ready channel interfaces of the 3x3 box blur: pixel input, result
// output and configuration write. Depends on bb3_pkg.
interface bb3_in_if;
  import bb3_pkg::*;
  logic valid;
  logic ready;
  pix_t pixel;
  logic pad;
  modport source (output valid, output pixel, output pad, input ready);
  modport sink   (input valid, input pixel, input pad, output ready);
  modport mon    (input valid, input pixel, input pad, input ready);
endinterface

interface bb3_out_if;
  import bb3_pkg::*;
  logic valid;
  logic ready;
  pix_t blurred;
  logic last_of_frame;
  modport source (output valid, output blurred, output last_of_frame, input ready);
  modport sink   (input valid, input blurred, input last_of_frame, output ready);
  modport mon    (input valid, input blurred, input last_of_frame, input ready);
endinterface

interface bb3_cfg_if;
  import bb3_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

### sv/bb3_line_store.sv
// Line store: one write port, one registered read port, write data
// forwarded when both ports hit the same address. No package needed.
module bb3_line_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= (we && (waddr == raddr)) ? wdata : mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/bb3_col_cell.sv
// One column cell of the blur window: holds three pixels, takes its
// neighbour's column on a shift and gives its masked column sum. Uses bb3_pkg.
module bb3_col_cell (
  input  logic               clk,
  input  bb3_pkg::cell_ctl_t ctl,
  input  bb3_pkg::col_t      din,
  input  bb3_pkg::sum_en_t   sen,
  output bb3_pkg::col_t      dout,
  output bb3_pkg::csum_t     csum
);
  import bb3_pkg::*;

  col_t col_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_r <= ctl.clr ? '0 : din;
    end
  end

  always_comb begin
    csum = '0;
    for (int i = 0; i < 3; i++) begin
      if (sen.row_en[i] && sen.col_en) begin
        csum = csum + CSUM_W'(col_r[i]);
      end
    end
  end

  assign dout = col_r;

endmodule

### sv/box_blur_3x3.sv
// 3x3 box blur, zero padded, over a raster-order pixel stream.
// Depends on bb3_pkg, bb3_if, bb3_line_store and bb3_col_cell.
//
// Channels: in_s takes one item (pixel, pad) per accepted handshake; out_s
// gives blurred = neighbourhood sum / 9 (truncated) and marks the frame's
// final pixel with last_of_frame. cfg_s writes frame_width (index 0) and
// frame_height (index 1); a write restarts the frame, other indexes do
// nothing. cfg_s is always ready; in_s is held off while cfg_s is valid.
// After the frame's pixels the source sends frame_width+1 pad items.
// Throughput: one item per cycle while out_s is not stalled and cfg_s is idle,
// set by the single read and single write of the line store per item; the
// window cells shift once per item. The result for pixel p is computed
// when item p+frame_width+1 is accepted, then passes the sum and divide stages.
// Reset: width 1024 (clamped to MAX_WIDTH), height 1, counters cleared, window
// cleared at the first item; line store data undefined and never used unmasked.
// Stall: the output register holds while out_s.ready is low; the sum stage
// and the window stage fill behind it, then in_s.ready drops.
module box_blur_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  bb3_in_if.sink         in_s,
  bb3_out_if.source      out_s,
  bb3_cfg_if.sink        cfg_s
);
  import bb3_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int OROW_W = $clog2(MAX_HEIGHT);

  // frame size, stored already clamped
  logic [WID_W-1:0]  w_r;
  logic [HGT_W-1:0]  h_r;

  logic [COL_W-1:0]  in_col_r,  in_col_nxt;
  logic [ROW_W-1:0]  in_row_r,  in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;
  logic              clear_r,   clear_nxt;

  logic              pend_r;
  logic              pend_last_r;
  win_mask_t         mask_r;
  logic              s2_v_r;
  logic              s2_last_r;
  sum_t              s2_sum_r;
  logic              out_v_r;
  logic              out_last_r;
  pix_t              out_blur_r;

  logic adv3, adv2, in_acc, cfg_acc, cfg_hit;

  assign adv3    = !out_v_r || out_s.ready;
  assign adv2    = !s2_v_r || adv3;
  assign in_s.ready = !cfg_s.valid && (!pend_r || adv2);
  assign in_acc  = in_s.valid && in_s.ready;
  assign cfg_s.ready = 1'b1;
  assign cfg_acc = cfg_s.valid;
  assign cfg_hit = cfg_acc &&
                   ((cfg_s.index == REG_FRAME_WIDTH) || (cfg_s.index == REG_FRAME_HEIGHT));

  // ---------------- position counters ----------------
  logic [COL_W:0]    w_ext;
  logic [OROW_W:0]   h_ext;
  logic [COL_W:0]    icol_p1, ocol_p1;
  logic [OROW_W:0]   orow_p1;
  logic              icol_wrap, ocol_wrap;
  logic [COL_W-1:0]  in_col_step, out_col_step;
  logic [ROW_W-1:0]  in_row_step;
  logic [OROW_W-1:0] out_row_step;
  logic              emit, out_last, beyond;
  win_mask_t         mask_now;

  assign w_ext   = (COL_W+1)'(w_r);
  assign h_ext   = (OROW_W+1)'(h_r);
  assign icol_p1 = {1'b0, in_col_r} + (COL_W+1)'(1);
  assign ocol_p1 = {1'b0, out_col_r} + (COL_W+1)'(1);
  assign orow_p1 = {1'b0, out_row_r} + (OROW_W+1)'(1);

  assign icol_wrap    = icol_p1 >= w_ext;
  assign in_col_step  = icol_wrap ? '0 : icol_p1[COL_W-1:0];
  assign in_row_step  = icol_wrap ? in_row_r + ROW_W'(1) : in_row_r;
  assign ocol_wrap    = ocol_p1 >= w_ext;
  assign out_col_step = ocol_wrap ? '0 : ocol_p1[COL_W-1:0];
  assign out_row_step = ocol_wrap ? orow_p1[OROW_W-1:0] : out_row_r;

  // results start once the stream is one row and one pixel ahead
  assign emit     = (in_row_r >= ROW_W'(2)) ||
                    ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
  assign out_last = (ocol_p1 == w_ext) && (orow_p1 == h_ext);
  assign beyond   = in_row_r >= ROW_W'(h_r);

  assign mask_now.row_en = {orow_p1 < h_ext, 1'b1, out_row_r != '0};
  assign mask_now.col_en = {ocol_p1 < w_ext, 1'b1, out_col_r != '0};

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    clear_nxt   = clear_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      clear_nxt   = 1'b1;
    end else if (in_acc) begin
      clear_nxt = 1'b0;
      if (emit && out_last) begin
        // frame done: restart after this item
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        clear_nxt   = 1'b1;
      end else begin
        in_col_nxt = in_col_step;
        in_row_nxt = in_row_step;
        if (emit) begin
          out_col_nxt = out_col_step;
          out_row_nxt = out_row_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= WID_W'((MAX_WIDTH < RESET_WIDTH) ? MAX_WIDTH : RESET_WIDTH);
      h_r       <= HGT_W'(RESET_HEIGHT);
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      clear_r   <= 1'b1;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      clear_r   <= clear_nxt;
      if (cfg_acc) begin
        case (cfg_s.index)
          REG_FRAME_WIDTH: begin
            if (cfg_s.data[FW_BITS-1:0] == '0) begin
              w_r <= WID_W'(1);
            end else if (int'(cfg_s.data[FW_BITS-1:0]) > MAX_WIDTH) begin
              w_r <= WID_W'(MAX_WIDTH);
            end else begin
              w_r <= WID_W'(cfg_s.data[FW_BITS-1:0]);
            end
          end
          REG_FRAME_HEIGHT: begin
            if (cfg_s.data[FH_BITS-1:0] == '0) begin
              h_r <= HGT_W'(1);
            end else if (int'(cfg_s.data[FH_BITS-1:0]) > MAX_HEIGHT) begin
              h_r <= HGT_W'(MAX_HEIGHT);
            end else begin
              h_r <= HGT_W'(cfg_s.data[FH_BITS-1:0]);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------- line store: {two above, above} per column ----------------
  logic [2*PIX_W-1:0] ls_rdata, ls_wdata;
  logic [COL_W-1:0]   ls_raddr;
  pix_t               px_a, px_b, px_v;

  assign px_a     = ls_rdata[2*PIX_W-1:PIX_W];
  assign px_b     = ls_rdata[PIX_W-1:0];
  assign px_v     = (in_s.pad || beyond) ? '0 : in_s.pixel;
  assign ls_wdata = {px_b, px_v};
  // read ahead at the column the next item will use
  assign ls_raddr = rst_n ? in_col_nxt : '0;

  bb3_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W),
    .DW    (2*PIX_W)
  ) u_ls (
    .clk   (clk),
    .we    (in_acc),
    .waddr (in_col_r),
    .wdata (ls_wdata),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  // ---------------- window: row of three column cells ----------------
  col_t      new_col;
  col_t      cdout [3];
  csum_t     csum  [3];
  cell_ctl_t cctl  [3];
  sum_en_t   csen  [3];

  assign new_col = {px_v, px_b, px_a};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cctl[k].shift     = in_acc;
      cctl[k].clr       = (k < 2) ? clear_r : 1'b0;
      csen[k].row_en    = mask_r.row_en;
      csen[k].col_en    = mask_r.col_en[k];
    end
  end

  bb3_col_cell u_cell0 (
    .clk (clk), .ctl (cctl[0]), .din (cdout[1]), .sen (csen[0]),
    .dout (cdout[0]), .csum (csum[0])
  );
  bb3_col_cell u_cell1 (
    .clk (clk), .ctl (cctl[1]), .din (cdout[2]), .sen (csen[1]),
    .dout (cdout[1]), .csum (csum[1])
  );
  bb3_col_cell u_cell2 (
    .clk (clk), .ctl (cctl[2]), .din (new_col), .sen (csen[2]),
    .dout (cdout[2]), .csum (csum[2])
  );

  // ---------------- sum and divide stages ----------------
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(s2_sum_r) * PROD_W'(DIV9_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_r <= emit;
      end else if (adv2) begin
        pend_r <= 1'b0;
      end
      if (adv2) begin
        s2_v_r <= pend_r;
      end
      if (adv3) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      mask_r      <= mask_now;
      pend_last_r <= out_last;
    end
    if (adv2 && pend_r) begin
      s2_sum_r  <= SUM_W'(csum[0]) + SUM_W'(csum[1]) + SUM_W'(csum[2]);
      s2_last_r <= pend_last_r;
    end
    if (adv3 && s2_v_r) begin
      out_blur_r <= prod[DIV9_SHIFT +: PIX_W];
      out_last_r <= s2_last_r;
    end
  end

  assign out_s.valid         = out_v_r;
  assign out_s.blurred       = out_blur_r;
  assign out_s.last_of_frame = out_last_r;

endmodule

### sv/bb3_checker.sv
// Port-level checks for box_blur_3x3 and the bind that attaches them.
// Depends on bb3_pkg and the channel interfaces in bb3_if.
module bb3_checker (
  input logic       clk,
  input logic       rst_n,
  bb3_in_if.sink    in_s,
  bb3_out_if.source out_s,
  bb3_cfg_if.sink   cfg_s
);
  import bb3_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && !out_s.ready) |=> out_s.valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && !out_s.ready) |=>
      ($stable(out_s.blurred) && $stable(out_s.last_of_frame)))
    else $error("stalled result changed");

  // a free output side must never hold off the input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.ready && !cfg_s.valid) |-> in_s.ready)
    else $error("input stalled with output free");

  // a new result comes from an accepted input item
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_s.valid) |-> $past(in_s.valid && in_s.ready, 3))
    else $error("result without a matching input item");

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (
  .clk   (clk),
  .rst_n (rst_n),
  .in_s  (in_s),
  .out_s (out_s),
  .cfg_s (cfg_s)
);

### tb/sv/box_blur_3x3_test.sv
// Self-checking bench for box_blur_3x3: drives pixel items and register writes,
// predicts every blurred result in a scoreboard class and compares it on arrival.
// Depends on bb3_pkg, the channel interfaces in bb3_if and the box_blur_3x3 RTL.
module box_blur_3x3_test;
  import bb3_pkg::*;

  localparam int LINE_MAX     = 1024;
  localparam int ROW_MAX      = 4096;
  localparam int BOX_AREA     = 9;
  localparam int DRAIN_CYCLES = 8;
  localparam int LIMIT_TIME   = 2000000;
  localparam int RANDOM_ITEMS = 780;
  localparam int HOLD_STRETCH = 400;
  localparam int REPORT_MAX   = 10;
  localparam int NO_HOLD      = -1;
  localparam pix_t PIX_MAX    = '1;
  localparam pix_t PIX_MIN    = '0;
  localparam cfg_idx_t REG_UNUSED = '1;

  typedef struct packed {
    pix_t blurred;
    logic last_of_frame;
  } blur_result_t;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  class blur_scoreboard;
    logic [FW_BITS-1:0] width_reg;
    logic [FH_BITS-1:0] height_reg;
    pix_t line_above [LINE_MAX];
    pix_t line_two_above [LINE_MAX];
    pix_t win [3][3];
    int unsigned in_col, in_row, out_col, out_row;
    blur_result_t expected_q[$];
    int errors;
    int results_seen;

    function new();
      width_reg  = FW_BITS'(RESET_WIDTH);
      height_reg = FH_BITS'(RESET_HEIGHT);
      foreach (line_above[i]) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      errors       = 0;
      results_seen = 0;
      restart();
    endfunction

    function void restart();
      foreach (win[i, j]) win[i][j] = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = data[FW_BITS-1:0];
        restart();
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = data[FH_BITS-1:0];
        restart();
      end
    endfunction

    function void note_pixel(pix_t pixel, logic pad);
      int unsigned w, h, r, c, idx, sum;
      int rr, cc;
      pix_t v, top, mid;
      logic emit;
      blur_result_t res;
      w = clamp_dim(width_reg, LINE_MAX);
      h = clamp_dim(height_reg, ROW_MAX);
      r = in_row;
      c = in_col;
      // pads and anything past the frame's rows enter as zero
      v = (pad || r >= h) ? PIX_MIN : pixel;
      idx = (c < LINE_MAX) ? c : 0;
      top = line_two_above[idx];
      mid = line_above[idx];
      line_two_above[idx] = mid;
      line_above[idx]     = v;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = v;
      // a result is due once the stream is width+1 items ahead of it
      emit = (r >= 2) || (r == 1 && c >= 1);
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      in_col = c;
      in_row = r;
      if (!emit) return;
      sum = 0;
      for (int dr = 0; dr < 3; dr++) begin
        rr = int'(out_row) - 1 + dr;
        if (rr < 0 || rr >= int'(h)) continue;
        for (int dc = 0; dc < 3; dc++) begin
          cc = int'(out_col) - 1 + dc;
          if (cc < 0 || cc >= int'(w)) continue;
          sum += win[dr][dc];
        end
      end
      res.blurred       = pix_t'(sum / BOX_AREA);
      res.last_of_frame = (out_row == h - 1) && (out_col == w - 1);
      expected_q.push_back(res);
      if (res.last_of_frame) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void check_result(pix_t blurred, logic last_of_frame);
      blur_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("result %0d unexpected: blurred=%0d last_of_frame=%0b",
                   results_seen, blurred, last_of_frame);
        return;
      end
      want = expected_q.pop_front();
      if (want.blurred !== blurred || want.last_of_frame !== last_of_frame) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("result %0d: expected blurred=%0d last=%0b, got blurred=%0d last=%0b",
                   results_seen, want.blurred, want.last_of_frame, blurred, last_of_frame);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bb3_in_if  in_ch ();
  bb3_out_if out_ch ();
  bb3_cfg_if cfg_ch ();

  box_blur_3x3 #(
    .MAX_WIDTH (LINE_MAX),
    .MAX_HEIGHT(ROW_MAX)
  ) dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_ch),
    .out_s(out_ch),
    .cfg_s(cfg_ch)
  );

  blur_scoreboard sb;
  int src_idle_pct;
  int rx_stall_pct;
  int hold_cycles;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #LIMIT_TIME;
    $display("box_blur_3x3: mismatch");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= (int'($urandom_range(99)) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.blurred, out_ch.last_of_frame);
  end

  task automatic send_item(pix_t pixel, logic pad);
    while (int'($urandom_range(99)) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel <= pixel;
    in_ch.pad   <= pad;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_pixel(pixel, pad);
    items_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // items that owe no result may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(cfg_data_t wdata, cfg_data_t hdata);
    drain();
    write_reg(REG_FRAME_WIDTH, wdata);
    write_reg(REG_FRAME_HEIGHT, hdata);
  endtask

  // send a whole frame plus its flush, or only the first cut items of it
  task automatic send_frame(int w, int h, int cut, int hold_at);
    int total;
    logic pad;
    total = w * h + w + 1;
    if (cut > 0 && cut < total) total = cut;
    for (int n = 0; n < total; n++) begin
      if (n == hold_at) hold_cycles = HOLD_STRETCH;
      if (n < w * h) pad = ($urandom_range(15) == 0);
      else pad = ($urandom_range(7) != 0);
      send_item(pix_t'($urandom), pad);
    end
  endtask

  initial begin
    int base, target, w, h, frames, cut;
    cfg_data_t wdata;
    sb = new();
    src_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles  = 0;
    items_sent   = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.pixel  <= '0;
    in_ch.pad    <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 frame: saturated and zero pixels, a pad inside the frame, a
    // non-pad item after the frame's pixels
    configure(cfg_data_t'(3), cfg_data_t'(3));
    repeat (4) send_item(PIX_MAX, 1'b0);
    send_item(PIX_MAX, 1'b1);
    send_item(PIX_MIN, 1'b0);
    send_item(PIX_MIN, 1'b0);
    repeat (3) send_item(PIX_MAX, 1'b0);
    repeat (3) send_item(PIX_MIN, 1'b1);

    // zero width and height count as one
    configure('0, '0);
    send_item(PIX_MAX, 1'b0);
    send_item(PIX_MAX, 1'b1);
    send_item(PIX_MIN, 1'b1);

    drain();
    write_reg(REG_UNUSED, '1);
    configure(cfg_data_t'(2), cfg_data_t'(1));
    send_item(PIX_MIN, 1'b0);
    send_item(PIX_MAX, 1'b0);
    repeat (3) send_item(PIX_MAX, 1'b1);

    base = items_sent;
    for (int sect = 0; sect < 3; sect++) begin
      case (sect)
        0: begin
          src_idle_pct = 25;
          rx_stall_pct = 52;
        end
        1: begin
          src_idle_pct = 52;
          rx_stall_pct = 25;
        end
        default: begin
          src_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase
      target = base + RANDOM_ITEMS * (sect + 1) / 3;
      while (items_sent < target) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        h = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
        // bits above the width field are dropped by the block
        wdata = cfg_data_t'(w) | (cfg_data_t'($urandom_range(3)) << FW_BITS);
        if ($urandom_range(15) == 0) begin
          wdata = cfg_data_t'($urandom_range(3)) << FW_BITS;
          w = 1;
        end
        configure(wdata, cfg_data_t'(h));
        frames = $urandom_range(3, 1);
        for (int f = 0; f < frames; f++) begin
          cut = 0;
          if (f == frames - 1 && $urandom_range(9) == 0) cut = $urandom_range(w * h + w, 1);
          send_frame(w, h, cut, NO_HOLD);
        end
      end
    end

    // long receiver hold-off while the sender keeps offering items
    configure(cfg_data_t'(4), cfg_data_t'(30));
    send_frame(4, 30, 0, 6);

    configure(cfg_data_t'(1), cfg_data_t'(ROW_MAX));
    send_frame(1, ROW_MAX, 40, NO_HOLD);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("box_blur_3x3: match");
    end else begin
      $display("box_blur_3x3: mismatch");
    end
    $finish;
  end

endmodule
